[rtl/bmp_pkg.sv]
`default_nettype none

package bmp_pkg;

	localparam int NUM_TERMINALS_DEF = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_POLLING       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIME_MS         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MASTER_RETRIES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMINAL_RETRIES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_DATA            = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_REPLY           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_RETRY           = 3'd6;

	localparam logic [1:0] LINE_SILENT = 2'd0;
	localparam logic [1:0] LINE_GOOD   = 2'd1;

	localparam logic [1:0] STRIKE_NONE     = 2'd0;
	localparam logic [1:0] STRIKE_BAD_COMM = 2'd1;
	localparam logic [1:0] STRIKE_BAD_RPLY = 2'd2;
	localparam logic [1:0] STRIKE_NO_RPLY  = 2'd3;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		PH_CALL   = 2'd0,
		PH_LISTEN = 2'd1,
		PH_ASK    = 2'd2,
		PH_MASTER = 2'd3
	} phase_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [1:0]  line_reading;
		logic [7:0]  reply_method;
	} in_item_t;

	typedef struct packed {
		logic        send_request;
		logic [7:0]  send_code;
		logic [2:0]  target_terminal;
		logic [1:0]  strike_kind;
		logic        accept_data;
		logic        terminal_done;
		logic        round_done;
		logic [1:0]  phase_now;
	} out_item_t;

	typedef struct packed {
		logic        enable_polling;
		logic [15:0] wait_time_ms;
		logic [7:0]  max_master_retries;
		logic [7:0]  max_terminal_retries;
		logic [7:0]  code_data;
		logic [7:0]  code_reply;
		logic [7:0]  code_retry;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] deadline;
		logic [7:0]  term_retry;
		logic [7:0]  master_retry;
	} core_state_t;

	typedef struct packed {
		logic        send_request;
		logic [7:0]  send_code;
		logic [1:0]  strike_kind;
		logic        accept_data;
		logic        terminal_done;
	} step_res_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == CNT_MAX) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

[rtl/bmp_step.sv]
`default_nettype none

module bmp_step import bmp_pkg::*; (
	input  wire cfg_t        cfg,
	input  wire core_state_t st,
	input  wire in_item_t    item,
	output core_state_t      nxt,
	output step_res_t        res
);

	logic [31:0] new_deadline;
	logic        in_window;
	logic        good;
	logic        silent;
	logic        is_reply;
	logic        is_retry;
	logic        ask_ok;
	logic        master_out;

	assign new_deadline = item.now_ms + {16'd0, cfg.wait_time_ms};
	assign in_window    = item.now_ms < st.deadline;
	assign good         = item.line_reading == LINE_GOOD;
	assign silent       = item.line_reading == LINE_SILENT;
	assign is_reply     = item.reply_method == cfg.code_reply;
	assign is_retry     = item.reply_method == cfg.code_retry;
	assign ask_ok       = st.term_retry < cfg.max_terminal_retries;
	assign master_out   = st.master_retry >= cfg.max_master_retries;

	// next state
	always_comb begin
		nxt = st;
		if (cfg.enable_polling) begin
			unique case (st.phase)
				PH_CALL: begin
					nxt.deadline = new_deadline;
					nxt.phase    = PH_LISTEN;
				end
				PH_LISTEN: begin
					if (!in_window) begin
						nxt.phase = PH_CALL;
					end else if (good && is_reply) begin
						nxt.term_retry   = 8'd0;
						nxt.master_retry = 8'd0;
						nxt.phase        = PH_CALL;
					end else if (good && is_retry) begin
						nxt.master_retry = sat_inc(st.master_retry);
						nxt.phase        = PH_MASTER;
					end else if (!silent) begin
						nxt.term_retry = sat_inc(st.term_retry);
						nxt.phase      = PH_ASK;
					end
				end
				PH_ASK: begin
					if (ask_ok) begin
						nxt.deadline = new_deadline;
						nxt.phase    = PH_LISTEN;
					end else begin
						nxt.phase = PH_CALL;
					end
				end
				PH_MASTER: begin
					nxt.phase = PH_CALL;
				end
				default: begin
					nxt.phase = PH_CALL;
				end
			endcase
		end
	end

	// step outputs
	always_comb begin
		res = '0;
		if (cfg.enable_polling) begin
			unique case (st.phase)
				PH_CALL: begin
					res.send_request = 1'b1;
					res.send_code    = cfg.code_data;
				end
				PH_LISTEN: begin
					if (!in_window) begin
						res.strike_kind   = STRIKE_NO_RPLY;
						res.terminal_done = 1'b1;
					end else if (good && is_reply) begin
						res.accept_data   = 1'b1;
						res.terminal_done = 1'b1;
					end else if (good && is_retry) begin
						res.strike_kind = STRIKE_BAD_COMM;
					end else if (!silent) begin
						res.strike_kind = STRIKE_BAD_RPLY;
					end
				end
				PH_ASK: begin
					if (ask_ok) begin
						res.send_request = 1'b1;
						res.send_code    = cfg.code_retry;
					end else begin
						res.terminal_done = 1'b1;
					end
				end
				PH_MASTER: begin
					res.terminal_done = master_out;
				end
				default: begin
					res = '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/bus_master_poll_retry_fsm.sv]
// Registers: an accepted item enters the input register, then the result register.
// Throughput: one item per cycle while out_stall is low; the poll state updates as an item
// moves into the result register, so back-to-back steps see each other's state.
// Reset (arst_n low, asynchronous): phase call, counters and deadline zero,
// terminal 1, configuration registers at their defaults, both stages empty.
`default_nettype none

module bus_master_poll_retry_fsm import bmp_pkg::*; #(
	parameter int NUM_TERMINALS = NUM_TERMINALS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_idx,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_item,
	output logic                   out_valid,
	input  wire                    out_stall,
	output out_item_t              out_item
);

	localparam int TW = $clog2(NUM_TERMINALS);
	localparam logic [TW-1:0] TERM_FIRST = TW'(1);
	localparam logic [TW-1:0] TERM_LAST  = TW'(NUM_TERMINALS - 1);

	cfg_t          cfg_q;
	core_state_t   state_q;
	core_state_t   state_nxt;
	step_res_t     res;
	logic [TW-1:0] term_q;
	logic          s1_valid_s1;
	in_item_t      item_s1;
	logic          out_valid_q;
	out_item_t     out_item_q;
	logic          advance;
	logic          in_take;
	logic          last_term;

	assign in_stall  = s1_valid_s1 && out_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;
	assign advance   = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign last_term = term_q == TERM_LAST;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	bmp_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_polling       <= 1'b1;
			cfg_q.wait_time_ms         <= 16'd1000;
			cfg_q.max_master_retries   <= 8'd3;
			cfg_q.max_terminal_retries <= 8'd2;
			cfg_q.code_data            <= 8'd0;
			cfg_q.code_reply           <= 8'd1;
			cfg_q.code_retry           <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ENABLE_POLLING:       cfg_q.enable_polling <= cfg_data[0];
				CFG_WAIT_TIME_MS:         cfg_q.wait_time_ms <= cfg_data;
				CFG_MAX_MASTER_RETRIES:   cfg_q.max_master_retries <= cfg_data[7:0];
				CFG_MAX_TERMINAL_RETRIES: cfg_q.max_terminal_retries <= cfg_data[7:0];
				CFG_CODE_DATA:            cfg_q.code_data <= cfg_data[7:0];
				CFG_CODE_REPLY:           cfg_q.code_reply <= cfg_data[7:0];
				CFG_CODE_RETRY:           cfg_q.code_retry <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_take) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_CALL;
			state_q.deadline     <= 32'd0;
			state_q.term_retry   <= 8'd0;
			state_q.master_retry <= 8'd0;
			term_q               <= TERM_FIRST;
		end else if (advance) begin
			state_q <= state_nxt;
			if (res.terminal_done) begin
				term_q <= last_term ? TERM_FIRST : term_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.send_request    <= res.send_request;
			out_item_q.send_code       <= res.send_code;
			out_item_q.target_terminal <= 3'(term_q);
			out_item_q.strike_kind     <= res.strike_kind;
			out_item_q.accept_data     <= res.accept_data;
			out_item_q.terminal_done   <= res.terminal_done;
			out_item_q.round_done      <= res.terminal_done && last_term;
			out_item_q.phase_now       <= state_nxt.phase;
		end
	end

`ifndef ASSERT_OFF
	a_round_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.round_done |-> out_item_q.terminal_done)
		else $error("round done without terminal done");

	a_accept_ends_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.accept_data |->
		out_item_q.terminal_done && out_item_q.phase_now == PH_CALL)
		else $error("accepted reply did not finish terminal");

	a_send_then_listen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.send_request |-> out_item_q.phase_now == PH_LISTEN)
		else $error("request sent without entering listen");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("input stage did not move into empty result register");
`endif

endmodule

`default_nettype wire
